### rtl/c3v_pkg.sv
// Shared types and constants for the 3x3 three-channel valid convolution unit.
// No dependencies; every other file in rtl imports this package.
`timescale 1ns / 1ps
`default_nettype none

package c3v_pkg;

  localparam int NUM_CH      = 3;
  localparam int NUM_TAPS    = 9;
  localparam int NUM_WEIGHTS = 27;
  localparam int PIX_W       = 8;
  localparam int COEF_W      = 16;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int IMG_W_W     = 11;
  localparam int PROD_W      = 25;
  localparam int LANE_W      = 28;
  localparam int MERGE_W     = 30;
  localparam int OUT_W       = 32;
  localparam int ENTRY_W     = 48;

  localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RESET = 11'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_WEIGHTS_0_3   = 3'd1,
    REG_WEIGHTS_4_7   = 3'd2,
    REG_WEIGHTS_8_11  = 3'd3,
    REG_WEIGHTS_12_15 = 3'd4,
    REG_WEIGHTS_16_19 = 3'd5,
    REG_WEIGHTS_20_23 = 3'd6,
    REG_WEIGHTS_24_26 = 3'd7
  } reg_idx_e;

  // One pixel, channel 0 in the lowest byte.
  typedef logic [NUM_CH-1:0][PIX_W-1:0] rgb_t;

  // Window of one channel, tap index row*3 + col, row 0 on top.
  typedef logic [NUM_TAPS-1:0][PIX_W-1:0] chan_win_t;
  typedef chan_win_t [NUM_CH-1:0] win_t;

  typedef logic [NUM_TAPS-1:0][COEF_W-1:0] lane_coef_t;
  typedef logic [NUM_WEIGHTS-1:0][COEF_W-1:0] coef_t;

  typedef struct packed {
    logic valid;
    logic emit;
    logic last;
  } stage_ctl_t;

endpackage

`default_nettype wire

### rtl/conv3x3_three_channel_valid_unit.sv
// Top level of the 3x3 three-channel valid convolution unit.
// Depends on c3v_pkg, c3v_line_buf, c3v_lane and c3v_merge.
//
// Channel  Handshake                   Payload
// in       in_valid_i / in_ready_o     start_of_frame_i, end_of_frame_i, sample_ch0..2_i
// out      out_valid_o / out_ready_i   conv_value_o, last_of_frame_o
// cfg      cfg_we_i                    cfg_index_i, cfg_data_i
//
// One word is taken per cycle while in_ready_o is high. The line store is one
// memory with a registered read; a word writes its column back when it leaves
// the first stage, with forwarding on the same column. Every stage has its
// own valid bit, so the unit keeps taking words while a result waits in the
// output register. Reset clears counters and valid bits.
`timescale 1ns / 1ps
`default_nettype none

module conv3x3_three_channel_valid_unit import c3v_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic                    start_of_frame_i,
  input  wire logic                    end_of_frame_i,
  input  wire logic [PIX_W-1:0]        sample_ch0_i,
  input  wire logic [PIX_W-1:0]        sample_ch1_i,
  input  wire logic [PIX_W-1:0]        sample_ch2_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic signed [OUT_W-1:0]      conv_value_o,
  output logic                         last_of_frame_o,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data_i
);

  logic [IMG_W_W-1:0]       image_width_q;
  coef_t                    coef_q;
  win_t                     win;
  stage_ctl_t               wctl;
  rgb_t                     pix;
  logic                     vp_q, lastp_q, vs_q, lasts_q;
  logic                     adv_w, adv_p, adv_s, prod_free, sum_free, merge_free;
  logic signed [LANE_W-1:0] lane_sum [NUM_CH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q <= IMAGE_WIDTH_RESET;
    end else if (cfg_we_i && (cfg_index_i == REG_IMAGE_WIDTH)) begin
      image_width_q <= cfg_data_i[IMG_W_W-1:0];
    end
  end

  for (genvar j = 0; j < NUM_WEIGHTS; j++) begin : g_coef
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        coef_q[j] <= '0;
      end else if (cfg_we_i && (cfg_index_i == reg_idx_e'(j / 4 + 1))) begin
        coef_q[j] <= cfg_data_i[COEF_W*(j % 4) +: COEF_W];
      end
    end
  end

  assign pix = {sample_ch2_i, sample_ch1_i, sample_ch0_i};

  assign adv_s     = vs_q & merge_free;
  assign sum_free  = ~vs_q | adv_s;
  assign adv_p     = vp_q & sum_free;
  assign prod_free = ~vp_q | adv_p;
  assign adv_w     = wctl.valid & prod_free;

  c3v_line_buf #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_line_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sof_i        (start_of_frame_i),
    .eof_i        (end_of_frame_i),
    .pix_i        (pix),
    .image_width_i(image_width_q),
    .down_free_i  (prod_free),
    .win_o        (win),
    .ctl_o        (wctl)
  );

  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    c3v_lane u_lane (
      .clk_i    (clk_i),
      .win_i    (win[c]),
      .coef_i   (coef_q[c*NUM_TAPS +: NUM_TAPS]),
      .prod_en_i(adv_w),
      .sum_en_i (adv_p),
      .sum_o    (lane_sum[c])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
      vs_q <= 1'b0;
    end else begin
      if (adv_w) begin
        vp_q <= wctl.emit;
      end else if (adv_p) begin
        vp_q <= 1'b0;
      end
      if (adv_p) begin
        vs_q <= 1'b1;
      end else if (adv_s) begin
        vs_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_w) begin
      lastp_q <= wctl.last;
    end
    if (adv_p) begin
      lasts_q <= lastp_q;
    end
  end

  c3v_merge u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .lane0_i        (lane_sum[0]),
    .lane1_i        (lane_sum[1]),
    .lane2_i        (lane_sum[2]),
    .load_i         (adv_s),
    .last_i         (lasts_q),
    .out_ready_i    (out_ready_i),
    .free_o         (merge_free),
    .out_valid_o    (out_valid_o),
    .conv_value_o   (conv_value_o),
    .last_of_frame_o(last_of_frame_o)
  );

endmodule

`default_nettype wire

### rtl/c3v_line_buf.sv
// Raster position counters, two-row line store and the sliding 3x3x3 window.
// Depends on c3v_pkg.
`timescale 1ns / 1ps
`default_nettype none

module c3v_line_buf import c3v_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               sof_i,
  input  wire logic               eof_i,
  input  wire rgb_t               pix_i,
  input  wire logic [IMG_W_W-1:0] image_width_i,
  input  wire logic               down_free_i,
  output win_t                    win_o,
  output stage_ctl_t              ctl_o
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WRQ = $clog2(MAX_WIDTH + 1);
  localparam int WW  = (WRQ > IMG_W_W) ? WRQ : IMG_W_W;

  logic [CW-1:0]      col_q, col_d;
  logic [1:0]         row_q, row_d;
  logic               v1_q, v1_d;
  rgb_t               cur1_q;
  logic [CW-1:0]      col1_q;
  logic               emit1_q, last1_q;
  logic [ENTRY_W-1:0] rd_q;
  logic               byp_q;
  logic [ENTRY_W-1:0] byp_data_q;
  logic               vw_q, vw_d;
  logic               emitw_q, lastw_q;
  win_t               win_q;

  logic [ENTRY_W-1:0] mem [MAX_WIDTH];

  logic               accept, adv1, adv_w, emit_now;
  logic [CW-1:0]      col_now;
  logic [1:0]         row_now;
  logic [WW-1:0]      width_raw, eff_w, col_inc;
  logic [ENTRY_W-1:0] entry;
  rgb_t               up1, up2;

  assign adv_w      = vw_q & down_free_i;
  assign adv1       = v1_q & (~vw_q | adv_w);
  assign in_ready_o = ~v1_q | adv1;
  assign accept     = in_valid_i & in_ready_o;

  assign entry = byp_q ? byp_data_q : rd_q;
  assign up1   = entry[ENTRY_W/2-1:0];
  assign up2   = entry[ENTRY_W-1:ENTRY_W/2];

  assign col_now  = sof_i ? '0 : col_q;
  assign row_now  = sof_i ? 2'd0 : row_q;
  assign emit_now = (row_now >= 2'd2) && (col_now >= CW'(2));

  always_comb begin
    width_raw = WW'(image_width_i);
    if (width_raw < WW'(3)) begin
      eff_w = WW'(3);
    end else if (width_raw > WW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = width_raw;
    end
    col_inc = WW'(col_now) + WW'(1);
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (eof_i) begin
        col_d = '0;
        row_d = 2'd0;
      end else if (col_inc >= eff_w) begin
        col_d = '0;
        row_d = (row_now >= 2'd2) ? 2'd2 : row_now + 2'd1;
      end else begin
        col_d = col_inc[CW-1:0];
        row_d = row_now;
      end
    end
    v1_d = accept ? 1'b1 : (adv1 ? 1'b0 : v1_q);
    vw_d = adv1 ? 1'b1 : (adv_w ? 1'b0 : vw_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= 2'd0;
      v1_q  <= 1'b0;
      vw_q  <= 1'b0;
      byp_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      v1_q  <= v1_d;
      vw_q  <= vw_d;
      if (accept) begin
        byp_q <= adv1 && (col1_q == col_now);
      end
    end
  end

  // The word leaving the first stage writes its column while the next word
  // reads; a read of the same column takes the written data instead.
  always_ff @(posedge clk_i) begin
    if (adv1) begin
      mem[col1_q] <= {up1, cur1_q};
    end
    if (accept) begin
      rd_q       <= mem[col_now];
      byp_data_q <= {up1, cur1_q};
      cur1_q     <= pix_i;
      col1_q     <= col_now;
      emit1_q    <= emit_now;
      last1_q    <= eof_i;
    end
  end

  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    for (genvar r = 0; r < 3; r++) begin : g_row
      always_ff @(posedge clk_i) begin
        if (adv1) begin
          win_q[c][r*3]     <= win_q[c][r*3 + 1];
          win_q[c][r*3 + 1] <= win_q[c][r*3 + 2];
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv1) begin
        win_q[c][2] <= up2[c];
        win_q[c][5] <= up1[c];
        win_q[c][8] <= cur1_q[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      emitw_q <= emit1_q;
      lastw_q <= last1_q;
    end
  end

  assign win_o       = win_q;
  assign ctl_o.valid = vw_q;
  assign ctl_o.emit  = emitw_q;
  assign ctl_o.last  = lastw_q;

endmodule

`default_nettype wire

### rtl/c3v_lane.sv
// One channel lane: nine registered pixel-by-weight products, then their sum.
// Depends on c3v_pkg.
`timescale 1ns / 1ps
`default_nettype none

module c3v_lane import c3v_pkg::*; (
  input  wire logic                     clk_i,
  input  wire chan_win_t                win_i,
  input  wire lane_coef_t               coef_i,
  input  wire logic                     prod_en_i,
  input  wire logic                     sum_en_i,
  output logic signed [LANE_W-1:0]      sum_o
);

  logic signed [PROD_W-1:0] prod_q [NUM_TAPS];
  logic signed [LANE_W-1:0] acc;
  logic signed [LANE_W-1:0] sum_q;

  always_ff @(posedge clk_i) begin
    if (prod_en_i) begin
      for (int k = 0; k < NUM_TAPS; k++) begin
        prod_q[k] <= $signed({1'b0, win_i[k]}) * $signed(coef_i[k]);
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int k = 0; k < NUM_TAPS; k++) begin
      acc = acc + LANE_W'(prod_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_en_i) begin
      sum_q <= acc;
    end
  end

  assign sum_o = sum_q;

endmodule

`default_nettype wire

### rtl/c3v_merge.sv
// Merging stage: adds the three lane sums into the output register.
// Depends on c3v_pkg.
`timescale 1ns / 1ps
`default_nettype none

module c3v_merge import c3v_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic signed [LANE_W-1:0] lane0_i,
  input  wire logic signed [LANE_W-1:0] lane1_i,
  input  wire logic signed [LANE_W-1:0] lane2_i,
  input  wire logic                     load_i,
  input  wire logic                     last_i,
  input  wire logic                     out_ready_i,
  output logic                          free_o,
  output logic                          out_valid_o,
  output logic signed [OUT_W-1:0]       conv_value_o,
  output logic                          last_of_frame_o
);

  logic                      vo_q, vo_d;
  logic signed [MERGE_W-1:0] total;
  logic signed [OUT_W-1:0]   value_q;
  logic                      last_q;

  assign total  = MERGE_W'(lane0_i) + MERGE_W'(lane1_i) + MERGE_W'(lane2_i);
  assign free_o = ~vo_q | out_ready_i;
  assign vo_d   = load_i ? 1'b1 : (out_ready_i ? 1'b0 : vo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= vo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      value_q <= OUT_W'(total);
      last_q  <= last_i;
    end
  end

  assign out_valid_o     = vo_q;
  assign conv_value_o    = value_q;
  assign last_of_frame_o = last_q;

endmodule

`default_nettype wire

### dv/conv3x3_three_channel_valid_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for conv3x3_three_channel_valid_unit: drives raster pixel
// words and register writes, and tracks line store, window and sums on its own.
// Depends on c3v_pkg and the unit in rtl.

module conv3x3_three_channel_valid_unit_test;
  import c3v_pkg::*;

  localparam int MAX_W = 1024;
  localparam int IDLE_PCT = 11;
  localparam int RANDOM_WORDS = 1450;

  typedef struct {
    logic signed [OUT_W-1:0] value;
    logic                    last;
  } conv_result_t;

  class window_sum_board;
    logic [IMG_W_W-1:0]       width_reg;
    logic signed [COEF_W-1:0] coef [NUM_WEIGHTS];
    logic [ENTRY_W-1:0]       line_mem [MAX_W];
    logic [PIX_W-1:0]         win [NUM_CH][3][3];
    int unsigned              col_cnt;
    int unsigned              row_cnt;
    conv_result_t             sums_due [$];
    int                       errors;

    function new();
      width_reg = IMAGE_WIDTH_RESET;
      foreach (coef[k]) coef[k] = '0;
      foreach (line_mem[k]) line_mem[k] = '0;
      foreach (win[c, r, j]) win[c][r][j] = '0;
      col_cnt = 0;
      row_cnt = 0;
      errors = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      int base;
      int k;
      if (idx == REG_IMAGE_WIDTH) begin
        width_reg = data[IMG_W_W-1:0];
      end else begin
        base = (int'(idx) - 1) * 4;
        for (k = 0; k < 4; k++) begin
          if (base + k < NUM_WEIGHTS) coef[base + k] = data[COEF_W*k +: COEF_W];
        end
      end
    endfunction

    function void take_pixel(logic sof, logic eof, rgb_t cur);
      int unsigned        w;
      int unsigned        cidx;
      logic [ENTRY_W-1:0] entry;
      rgb_t               up1;
      rgb_t               up2;
      int                 acc;
      conv_result_t       res;
      w = width_reg;
      if (w < 3) w = 3;
      if (w > MAX_W) w = MAX_W;
      if (sof) begin
        col_cnt = 0;
        row_cnt = 0;
      end
      cidx = (col_cnt >= MAX_W) ? 0 : col_cnt;
      entry = line_mem[cidx];
      up1 = entry[23:0];
      up2 = entry[47:24];
      line_mem[cidx] = {up1, cur};
      for (int c = 0; c < NUM_CH; c++) begin
        for (int r = 0; r < 3; r++) begin
          win[c][r][0] = win[c][r][1];
          win[c][r][1] = win[c][r][2];
        end
        win[c][0][2] = up2[c];
        win[c][1][2] = up1[c];
        win[c][2][2] = cur[c];
      end
      if (row_cnt >= 2 && cidx >= 2) begin
        acc = 0;
        for (int c = 0; c < NUM_CH; c++)
          for (int r = 0; r < 3; r++)
            for (int j = 0; j < 3; j++)
              acc += int'(coef[c*9 + r*3 + j]) * int'(win[c][r][j]);
        res.value = acc;
        res.last = eof;
        sums_due.push_back(res);
      end
      if (eof) begin
        col_cnt = 0;
        row_cnt = 0;
      end else if (cidx + 1 >= w) begin
        col_cnt = 0;
        if (row_cnt < 2) row_cnt++;
      end else begin
        col_cnt = cidx + 1;
      end
    endfunction

    task flag_mismatch(string what);
      $display("%0t mismatch: %s", $time, what);
      errors++;
    endtask

    task check_sum(logic signed [OUT_W-1:0] got_value, logic got_last);
      conv_result_t want;
      if (sums_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected word, conv_value %0d", got_value));
        return;
      end
      want = sums_due.pop_front();
      if (got_value !== want.value)
        flag_mismatch($sformatf("conv_value got %0d want %0d", got_value, want.value));
      if (got_last !== want.last)
        flag_mismatch($sformatf("last_of_frame got %0b want %0b", got_last, want.last));
    endtask
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic                    start_of_frame_i = 1'b0;
  logic                    end_of_frame_i = 1'b0;
  logic [PIX_W-1:0]        sample_ch0_i = '0;
  logic [PIX_W-1:0]        sample_ch1_i = '0;
  logic [PIX_W-1:0]        sample_ch2_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [OUT_W-1:0] conv_value_o;
  logic                    last_of_frame_o;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i = '0;

  window_sum_board sb = new();
  logic            calm = 1'b0;
  int              ready_hold = 0;
  int              random_words = 0;

  conv3x3_three_channel_valid_unit #(
    .MAX_WIDTH(MAX_W)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .start_of_frame_i(start_of_frame_i),
    .end_of_frame_i  (end_of_frame_i),
    .sample_ch0_i    (sample_ch0_i),
    .sample_ch1_i    (sample_ch1_i),
    .sample_ch2_i    (sample_ch2_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .conv_value_o    (conv_value_o),
    .last_of_frame_o (last_of_frame_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        sb.take_pixel(start_of_frame_i, end_of_frame_i,
                      {sample_ch2_i, sample_ch1_i, sample_ch0_i});
      if (out_valid_o && out_ready_i) sb.check_sum(conv_value_o, last_of_frame_o);
    end
  end

  // The receiver counts its own hold-off once one is requested.
  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      out_ready_i <= 1'b0;
      ready_hold--;
    end else begin
      out_ready_i <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic rgb_t pick_pixel();
    rgb_t px;
    int   roll;
    for (int c = 0; c < NUM_CH; c++) begin
      roll = $urandom_range(99);
      px[c] = (roll < 10) ? 8'h00 : (roll < 20) ? 8'hFF : 8'($urandom);
    end
    return px;
  endfunction

  task automatic send_word(logic sof, logic eof, rgb_t px);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < IDLE_PCT);
    end
    in_valid_i       <= 1'b1;
    start_of_frame_i <= sof;
    end_of_frame_i   <= eof;
    sample_ch0_i     <= px[0];
    sample_ch1_i     <= px[1];
    sample_ch2_i     <= px[2];
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    sb.set_reg(idx, data);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic settle(int tail);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.sums_due.size() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  // Mostly whole frames; about one in five carries a stray start or end flag.
  task automatic send_frame(int w, int rows, bit open_frame);
    int   n;
    int   bad_at;
    logic sof;
    logic eof;
    n = w * rows;
    bad_at = ($urandom_range(99) < 20) ? $urandom_range(n - 1) : -1;
    for (int i = 0; i < n; i++) begin
      sof = (i == 0) && (open_frame || $urandom_range(99) >= 5);
      eof = (i == n - 1) && ($urandom_range(99) >= 5);
      if (i == bad_at && i != 0) begin
        if ($urandom_range(1)) sof = 1'b1;
        else eof = 1'b1;
      end
      send_word(sof, eof, pick_pixel());
      random_words++;
    end
  endtask

  task automatic write_weights(bit all_regs);
    logic [CFG_DATA_W-1:0] data;
    int                    roll;
    for (int i = int'(REG_WEIGHTS_0_3); i <= int'(REG_WEIGHTS_24_26); i++) begin
      if (all_regs || $urandom_range(1)) begin
        roll = $urandom_range(99);
        if (roll < 15) data = {4{16'h8000}};
        else if (roll < 30) data = {4{16'h7FFF}};
        else if (roll < 35) data = '0;
        else data = {$urandom, $urandom};
        write_reg(reg_idx_e'(i), data);
      end
    end
  endtask

  initial begin : stimulus
    int                    phase;
    int                    raw_w;
    int                    w_eff;
    int                    roll;
    int                    n;
    logic [CFG_DATA_W-1:0] data;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Width below range, weights at both extremes.
    write_reg(REG_IMAGE_WIDTH, '0);
    for (int i = 1; i < 8; i++)
      write_reg(reg_idx_e'(i), i[0] ? {4{16'h8000}} : {4{16'h7FFF}});
    for (int i = 0; i < 9; i++) send_word(i == 0, i == 8, {3{8'hFF}});
    // An end of frame on a pixel that yields no sum, then a frame with no end.
    send_word(1'b1, 1'b0, '0);
    send_word(1'b0, 1'b1, '0);
    for (int i = 0; i < 9; i++)
      send_word(1'b0, 1'b0, i[0] ? {8'h00, 8'hFF, 8'h00} : {8'hFF, 8'h00, 8'hFF});

    phase = 0;
    while (random_words < RANDOM_WORDS) begin
      settle(8);
      calm = (phase == 1);
      roll = $urandom_range(99);
      raw_w = (roll < 8) ? $urandom_range(2) : (roll < 35) ? 3 : $urandom_range(4, 24);
      w_eff = (raw_w < 3) ? 3 : raw_w;
      data = {$urandom, $urandom};
      data[IMG_W_W-1:0] = IMG_W_W'(raw_w);
      write_reg(REG_IMAGE_WIDTH, data);
      write_weights(phase == 0);
      if (phase == 2) ready_hold = 400;
      if (phase == 3) begin
        // Shrink the width in the middle of the third row.
        write_reg(REG_IMAGE_WIDTH, 64'd14);
        for (int i = 0; i < 37; i++) send_word(i == 0, 1'b0, pick_pixel());
        settle(8);
        write_reg(REG_IMAGE_WIDTH, 64'd5);
        for (int i = 0; i < 17; i++) send_word(1'b0, i == 16, pick_pixel());
        random_words += 54;
      end else if (phase == 4) begin
        // One full-width row, then a narrow width so the third row starts at once.
        data = {$urandom, $urandom};
        data[IMG_W_W-1:0] = $urandom_range(1) ? 11'd1024 : 11'h7FF;
        write_reg(REG_IMAGE_WIDTH, data);
        n = MAX_W + 12;
        for (int i = 0; i < n; i++) send_word(i == 0, 1'b0, pick_pixel());
        settle(8);
        write_reg(REG_IMAGE_WIDTH, 64'd3);
        for (int i = 0; i < 7; i++) send_word(1'b0, i == 6, pick_pixel());
        random_words += n + 7;
      end else begin
        n = $urandom_range(1, 3);
        for (int f = 0; f < n; f++) send_frame(w_eff, $urandom_range(3, 6), f == 0);
      end
      phase++;
    end
    calm = 1'b0;

    settle(20);
    if (sb.errors == 0) begin
      $display("[conv3x3_three_channel_valid_unit] OK");
    end else begin
      $display("[conv3x3_three_channel_valid_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[conv3x3_three_channel_valid_unit] ERROR");
    $finish;
  end

endmodule

### files.f
rtl/c3v_pkg.sv
rtl/c3v_line_buf.sv
rtl/c3v_lane.sv
rtl/c3v_merge.sv
rtl/conv3x3_three_channel_valid_unit.sv
dv/conv3x3_three_channel_valid_unit_test.sv
